// File: hw/rtl/dhcp_option_parser_macros.svh
// ----------------------------------------------------------------------------
// DHCP option parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DHCP_OPTION_PARSER_MACROS_SVH
`define DHCP_OPTION_PARSER_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define DOP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define DOP_ASSERT_IMPLIES(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/dop_pkg.sv
// ----------------------------------------------------------------------------
// DHCP option parser package
// Option codes, parse phases, record types and the field size lookup.
// ----------------------------------------------------------------------------
package dop_pkg;

  localparam logic [7:0] CODE_PAD         = 8'd0;
  localparam logic [7:0] CODE_NETMASK     = 8'd1;
  localparam logic [7:0] CODE_ROUTER      = 8'd3;
  localparam logic [7:0] CODE_NAME_SERVER = 8'd6;
  localparam logic [7:0] CODE_MTU         = 8'd26;
  localparam logic [7:0] CODE_BROADCAST   = 8'd28;
  localparam logic [7:0] CODE_LEASE       = 8'd51;
  localparam logic [7:0] CODE_MSG_TYPE    = 8'd53;
  localparam logic [7:0] CODE_SERVER_ID   = 8'd54;
  localparam logic [7:0] CODE_RENEWAL     = 8'd58;
  localparam logic [7:0] CODE_REBINDING   = 8'd59;
  localparam logic [7:0] CODE_END         = 8'd255;

  // Value bytes counted per option; saturates at the widest field.
  localparam int unsigned BODY_MAX = 4;
  localparam logic [2:0] BODY_SAT  = 3'(BODY_MAX);
  localparam logic [7:0] COUNT_SAT = 8'd255;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_LEN,
    PH_BODY,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0]  msg_type;
    logic [31:0] net_mask;
    logic [31:0] router_address;
    logic [31:0] bcast_address;
    logic [31:0] server_address;
    logic [31:0] first_name_server;
    logic [7:0]  name_server_count;
    logic [15:0] link_mtu;
    logic [31:0] lease_seconds;
    logic [31:0] renewal_seconds;
    logic [31:0] rebinding_seconds;
  } record_t;

  typedef struct packed {
    record_t rec;
    logic    truncated;
  } result_t;

  function automatic logic [2:0] field_size(input logic [7:0] code);
    logic [2:0] size;
    case (code)
      CODE_MSG_TYPE: size = 3'd1;
      CODE_MTU:      size = 3'd2;
      CODE_NETMASK, CODE_ROUTER, CODE_BROADCAST, CODE_SERVER_ID,
      CODE_NAME_SERVER, CODE_LEASE, CODE_RENEWAL, CODE_REBINDING:
                     size = 3'd4;
      default:       size = 3'd0;
    endcase
    return size;
  endfunction

endpackage

// File: hw/rtl/dhcp_option_parser.sv
// ----------------------------------------------------------------------------
// DHCP option parser
// Streaming code-length-value walker over the DHCP options area.
// ----------------------------------------------------------------------------
// Feed the options area one byte per word, starting right after the magic
// cookie, with last_byte set on the final byte of the packet. The block takes
// one byte every cycle while in_stall is low: each byte passes through a
// short state update in the same cycle it is accepted. Exactly one result
// word leaves per packet, either when the END code is seen as an option
// code (truncated 0) or on the last byte if no END came first (truncated 1).
// Bytes after END, up to and including the last byte, are dropped silently.
// The result sits in an output register backed by a one-word skid
// register, so input keeps flowing while a result waits; in_stall rises
// only when both registers hold undelivered words.
// ----------------------------------------------------------------------------
`include "dhcp_option_parser_macros.svh"

module dhcp_option_parser
  import dop_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  option_byte,
  input  logic        last_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  msg_type,
  output logic [31:0] net_mask,
  output logic [31:0] router_address,
  output logic [31:0] bcast_address,
  output logic [31:0] server_address,
  output logic [31:0] first_name_server,
  output logic [7:0]  name_server_count,
  output logic [15:0] link_mtu,
  output logic [31:0] lease_seconds,
  output logic [31:0] renewal_seconds,
  output logic [31:0] rebinding_seconds,
  output logic        truncated
);

  // Parse state
  phase_t      phase, phase_next;
  logic [7:0]  current_code, current_code_next;
  logic [7:0]  remaining_length, remaining_length_next;
  logic [2:0]  body_index, body_index_next;     // saturates at the widest field
  logic [31:0] value_shift, value_shift_next;
  record_t     rec, rec_next;

  // Result staging
  result_t     out_word, skid_word;
  logic        skid_valid;
  result_t     res_next;
  logic        emit;
  logic        clear;

  logic        accept;
  logic [2:0]  need;
  logic [31:0] value_acc;

  assign accept   = in_valid & ~in_stall;
  assign in_stall = skid_valid;

  assign need      = field_size(current_code);
  assign value_acc = {value_shift[23:0], option_byte};

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_TYPE: begin
        if (option_byte == CODE_END) begin
          phase_next = PH_DONE;
        end else if (option_byte != CODE_PAD) begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        phase_next = (option_byte == 8'd0) ? PH_TYPE : PH_BODY;
      end
      PH_BODY: begin
        if (remaining_length == 8'd1) begin
          phase_next = PH_TYPE;
        end
      end
      PH_DONE: phase_next = PH_DONE;
      default: phase_next = PH_TYPE;
    endcase
    // The last byte always closes the packet.
    if (last_byte) begin
      phase_next = PH_TYPE;
    end
  end

  // Datapath and result
  always_comb begin
    current_code_next     = current_code;
    remaining_length_next = remaining_length;
    body_index_next       = body_index;
    value_shift_next      = value_shift;
    rec_next              = rec;
    emit                  = 1'b0;
    clear                 = 1'b0;
    res_next.truncated    = 1'b0;

    case (phase)
      PH_TYPE: begin
        if (option_byte == CODE_END) begin
          emit  = 1'b1;
          clear = 1'b1;
        end else if (option_byte != CODE_PAD) begin
          current_code_next = option_byte;
        end
      end
      PH_LEN: begin
        remaining_length_next = option_byte;
        body_index_next       = 3'd0;
        value_shift_next      = 32'd0;
      end
      PH_BODY: begin
        if (body_index < need) begin
          value_shift_next = value_acc;
          // Commit once the field's final byte has arrived.
          if (body_index + 3'd1 == need) begin
            case (current_code)
              CODE_MSG_TYPE:  rec_next.msg_type          = value_acc[7:0];
              CODE_MTU:       rec_next.link_mtu          = value_acc[15:0];
              CODE_NETMASK:   rec_next.net_mask          = value_acc;
              CODE_ROUTER:    rec_next.router_address    = value_acc;
              CODE_BROADCAST: rec_next.bcast_address     = value_acc;
              CODE_SERVER_ID: rec_next.server_address    = value_acc;
              CODE_LEASE:     rec_next.lease_seconds     = value_acc;
              CODE_RENEWAL:   rec_next.renewal_seconds   = value_acc;
              CODE_REBINDING: rec_next.rebinding_seconds = value_acc;
              CODE_NAME_SERVER: begin
                // Keep the first server address; count complete ones up to COUNT_SAT.
                if (rec.name_server_count == 8'd0) begin
                  rec_next.first_name_server = value_acc;
                end
                if (rec.name_server_count != COUNT_SAT) begin
                  rec_next.name_server_count = rec.name_server_count + 8'd1;
                end
              end
              default: ;
            endcase
          end
        end
        if (body_index != BODY_SAT) begin
          body_index_next = body_index + 3'd1;
        end
        remaining_length_next = remaining_length - 8'd1;
      end
      PH_DONE: begin
        // Drop bytes until the packet ends.
        clear = last_byte;
      end
      default: ;
    endcase

    // Packet ended without END: emit what was gathered, including this byte.
    if (last_byte && phase != PH_DONE && !(phase == PH_TYPE && option_byte == CODE_END)) begin
      emit               = 1'b1;
      clear              = 1'b1;
      res_next.truncated = 1'b1;
    end

    res_next.rec = rec_next;
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_TYPE;
      current_code     <= 8'd0;
      remaining_length <= 8'd0;
      body_index       <= 3'd0;
      value_shift      <= 32'd0;
      rec              <= '0;
    end else if (accept) begin
      phase <= phase_next;
      if (clear) begin
        current_code     <= 8'd0;
        remaining_length <= 8'd0;
        body_index       <= 3'd0;
        value_shift      <= 32'd0;
        rec              <= '0;
      end else begin
        current_code     <= current_code_next;
        remaining_length <= remaining_length_next;
        body_index       <= body_index_next;
        value_shift      <= value_shift_next;
        rec              <= rec_next;
      end
    end
  end

  // Output register with one-word skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      // Output slot frees this cycle: advance skid first, else fresh result.
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= accept & emit;
      end else begin
        out_valid <= accept & emit;
      end
    end else if (accept && emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (accept && emit) begin
        out_word <= res_next;
      end
    end
    if (accept && emit && (skid_valid || (out_valid && out_stall))) begin
      skid_word <= res_next;
    end
  end

  assign msg_type          = out_word.rec.msg_type;
  assign net_mask          = out_word.rec.net_mask;
  assign router_address    = out_word.rec.router_address;
  assign bcast_address     = out_word.rec.bcast_address;
  assign server_address    = out_word.rec.server_address;
  assign first_name_server = out_word.rec.first_name_server;
  assign name_server_count = out_word.rec.name_server_count;
  assign link_mtu          = out_word.rec.link_mtu;
  assign lease_seconds     = out_word.rec.lease_seconds;
  assign renewal_seconds   = out_word.rec.renewal_seconds;
  assign rebinding_seconds = out_word.rec.rebinding_seconds;
  assign truncated         = out_word.truncated;

  // Assertions
  `DOP_ASSERT_IMPLIES(a_skid_behind_out, skid_valid, out_valid, "skid word without output word")
  `DOP_ASSERT_IMPLIES(a_body_len, phase == PH_BODY, remaining_length != 8'd0, "empty value phase")
  `DOP_ASSERT_IMPLIES(a_done_clear, phase == PH_DONE, rec == '0, "record not cleared after END")
  `DOP_ASSERT_ALWAYS(a_body_sat, body_index <= BODY_SAT, "value byte count past saturation")

endmodule

// File: tb/dhcp_option_parser_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DHCP option parser testbench
// Streams whole option areas into the parser, one byte per word, predicts the
// record each packet leaves behind, and checks every result word field by
// field. Both channels idle in random bursts, and the result side holds off
// once for a long stretch so that the parser backs up into its input.
// ----------------------------------------------------------------------------
module dhcp_option_parser_tb
  import dop_pkg::*;
();

  // One input word as queued for the driver.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stim_t;

  localparam int RANDOM_BYTES  = 200;
  localparam int NS_REPEATS    = 257;  // enough name server options to saturate the count
  localparam int HOLD_CYCLES   = 80;
  localparam int QUIET_TAIL    = 100;
  localparam int TAIL_CYCLES   = 20;
  localparam int LIMIT_NS      = 1_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  option_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  msg_type;
  logic [31:0] net_mask;
  logic [31:0] router_address;
  logic [31:0] bcast_address;
  logic [31:0] server_address;
  logic [31:0] first_name_server;
  logic [7:0]  name_server_count;
  logic [15:0] link_mtu;
  logic [31:0] lease_seconds;
  logic [31:0] renewal_seconds;
  logic [31:0] rebinding_seconds;
  logic        truncated;

  dhcp_option_parser dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .option_byte       (option_byte),
    .last_byte         (last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .msg_type          (msg_type),
    .net_mask          (net_mask),
    .router_address    (router_address),
    .bcast_address     (bcast_address),
    .server_address    (server_address),
    .first_name_server (first_name_server),
    .name_server_count (name_server_count),
    .link_mtu          (link_mtu),
    .lease_seconds     (lease_seconds),
    .renewal_seconds   (renewal_seconds),
    .rebinding_seconds (rebinding_seconds),
    .truncated         (truncated)
  );

  // Free-running clock, 2 ns period.
  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Stimulus store and run bookkeeping
  // --------------------------------------------------------------------------
  stim_t       byte_queue[$];   // words waiting for the driver
  logic [7:0]  pkt[$];          // packet under construction
  result_t     pending_records[$];
  result_t     want;

  int total_words;
  int words_in;
  int packets_in;
  int records_checked;
  int input_stall_cycles;
  int errors;
  int pressure_mark;
  int quiet_mark;
  bit long_hold;
  bit in_took;
  int gap_left;
  int stall_left;

  wire quiet;
  assign quiet = (words_in >= quiet_mark);

  // --------------------------------------------------------------------------
  // Record predictor: walks the option stream exactly as the parser should
  // and queues one expected record per packet.
  // --------------------------------------------------------------------------
  phase_t      scan_phase;
  logic [7:0]  opt_code;
  logic [7:0]  bytes_left;
  logic [7:0]  value_pos;
  logic [31:0] value_acc;
  record_t     rec_acc;

  // Number of value bytes each known option carries; unknown codes carry none.
  function automatic int value_width(input logic [7:0] code);
    case (code)
      CODE_MSG_TYPE: return 1;
      CODE_MTU:      return 2;
      CODE_NETMASK, CODE_ROUTER, CODE_BROADCAST, CODE_SERVER_ID,
      CODE_NAME_SERVER, CODE_LEASE, CODE_RENEWAL, CODE_REBINDING:
                     return 4;
      default:       return 0;
    endcase
  endfunction

  task automatic clear_scan();
    scan_phase = PH_TYPE;
    opt_code   = 8'd0;
    bytes_left = 8'd0;
    value_pos  = 8'd0;
    value_acc  = 32'd0;
    rec_acc    = '0;
  endtask

  // Land a completed value in its field. A later option overwrites an earlier
  // one, except the first name server, which keeps the first address seen.
  task automatic store_value(input logic [7:0] code, input logic [31:0] v);
    case (code)
      CODE_MSG_TYPE:  rec_acc.msg_type          = v[7:0];
      CODE_MTU:       rec_acc.link_mtu          = v[15:0];
      CODE_NETMASK:   rec_acc.net_mask          = v;
      CODE_ROUTER:    rec_acc.router_address    = v;
      CODE_BROADCAST: rec_acc.bcast_address     = v;
      CODE_SERVER_ID: rec_acc.server_address    = v;
      CODE_LEASE:     rec_acc.lease_seconds     = v;
      CODE_RENEWAL:   rec_acc.renewal_seconds   = v;
      CODE_REBINDING: rec_acc.rebinding_seconds = v;
      CODE_NAME_SERVER: begin
        if (rec_acc.name_server_count == 8'd0) rec_acc.first_name_server = v;
        if (rec_acc.name_server_count != COUNT_SAT)
          rec_acc.name_server_count = rec_acc.name_server_count + 8'd1;
      end
      default: ;
    endcase
  endtask

  task automatic close_record(input logic trunc);
    result_t r;
    r.rec       = rec_acc;
    r.truncated = trunc;
    pending_records.push_back(r);
    clear_scan();
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic last);
    int need;
    case (scan_phase)
      PH_TYPE: begin
        if (b == CODE_END) begin
          // END closes the record cleanly; drop everything up to the last byte
          close_record(1'b0);
          if (!last) scan_phase = PH_DONE;
          return;
        end
        if (b != CODE_PAD) begin
          opt_code   = b;
          scan_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        bytes_left = b;
        value_pos  = 8'd0;
        value_acc  = 32'd0;
        scan_phase = (b == 8'd0) ? PH_TYPE : PH_BODY;
      end
      PH_BODY: begin
        need = value_width(opt_code);
        // Only the leading bytes a field needs count; a short option never commits
        if (value_pos < need) begin
          value_acc = {value_acc[23:0], b};
          if (value_pos + 1 == need) store_value(opt_code, value_acc);
        end
        if (value_pos != 8'hFF) value_pos = value_pos + 8'd1;
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'd0) scan_phase = PH_TYPE;
      end
      default: begin
        if (last) clear_scan();
        return;
      end
    endcase
    // Packet ran out before END: the byte above still counts, then flag it
    if (last) close_record(1'b1);
  endtask

  initial clear_scan();

  // --------------------------------------------------------------------------
  // Packet construction
  // --------------------------------------------------------------------------
  function automatic logic [7:0] known_code(input int k);
    case (k)
      0:       return CODE_MSG_TYPE;
      1:       return CODE_NETMASK;
      2:       return CODE_ROUTER;
      3:       return CODE_BROADCAST;
      4:       return CODE_SERVER_ID;
      5:       return CODE_NAME_SERVER;
      6:       return CODE_MTU;
      7:       return CODE_LEASE;
      8:       return CODE_RENEWAL;
      default: return CODE_REBINDING;
    endcase
  endfunction

  // Value bytes lean toward all-zero and all-one to hit the field extremes.
  function automatic logic [7:0] value_byte();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_option(input logic [7:0] code, input int len);
    pkt.push_back(code);
    pkt.push_back(8'(len));
    repeat (len) pkt.push_back(value_byte());
  endtask

  // Move the packet under construction into the driver queue, marking its
  // final byte as last.
  task automatic send_packet();
    stim_t w;
    foreach (pkt[i]) begin
      w.data = pkt[i];
      w.last = (i == pkt.size() - 1);
      byte_queue.push_back(w);
    end
    pkt.delete();
  endtask

  task automatic build_random_packet();
    int n;
    int sel;
    int lsel;
    int w;
    int len;
    int keep;
    logic [7:0] code;
    n = $urandom_range(0, 7);
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        pkt.push_back(CODE_PAD);
      end else begin
        code = (sel < 75) ? known_code($urandom_range(0, 9)) : 8'($urandom_range(1, 254));
        w    = value_width(code);
        lsel = $urandom_range(0, 39);
        // mostly exact lengths; some empty, short, padded-out and rare huge ones
        if (lsel < 24)      len = w;
        else if (lsel < 28) len = 0;
        else if (lsel < 32) len = $urandom_range(0, 3);
        else if (lsel < 39) len = $urandom_range(w, w + 6);
        else                len = $urandom_range(0, 255);
        add_option(code, len);
      end
    end
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      // clean END, sometimes followed by junk the parser must drop
      pkt.push_back(CODE_END);
      repeat ($urandom_range(0, 2)) pkt.push_back(8'($urandom_range(0, 255)));
    end else if (sel < 9) begin
      // cut short anywhere, often mid-option
      if (pkt.size() == 0) pkt.push_back(8'($urandom_range(0, 255)));
      keep = $urandom_range(1, pkt.size());
      while (pkt.size() > keep) void'(pkt.pop_back());
    end else begin
      pkt.delete();
      repeat ($urandom_range(1, 16)) pkt.push_back(8'($urandom_range(0, 255)));
    end
    send_packet();
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, got_v);
      errors++;
    end
  endtask

  task automatic compare_record(input result_t r);
    check_field("msg_type", 32'(r.rec.msg_type), 32'(msg_type));
    check_field("net_mask", r.rec.net_mask, net_mask);
    check_field("router_address", r.rec.router_address, router_address);
    check_field("bcast_address", r.rec.bcast_address, bcast_address);
    check_field("server_address", r.rec.server_address, server_address);
    check_field("first_name_server", r.rec.first_name_server, first_name_server);
    check_field("name_server_count", 32'(r.rec.name_server_count),
                32'(name_server_count));
    check_field("link_mtu", 32'(r.rec.link_mtu), 32'(link_mtu));
    check_field("lease_seconds", r.rec.lease_seconds, lease_seconds);
    check_field("renewal_seconds", r.rec.renewal_seconds, renewal_seconds);
    check_field("rebinding_seconds", r.rec.rebinding_seconds, rebinding_seconds);
    check_field("truncated", 32'(r.truncated), 32'(truncated));
  endtask

  // Monitor: sample both channels at the rising edge. Check the outgoing
  // record before absorbing the incoming byte, so a result never meets an
  // expectation queued in the same cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_records.size() == 0) begin
          $error("result word arrived with no record expected");
          errors++;
        end else begin
          want = pending_records.pop_front();
          compare_record(want);
          records_checked++;
        end
      end
      if (in_valid && in_stall) input_stall_cycles++;
      if (in_valid && !in_stall) begin
        absorb_byte(option_byte, last_byte);
        words_in++;
        if (last_byte) packets_in++;
      end
    end
    in_took <= !rst && in_valid && !in_stall;
  end

  // --------------------------------------------------------------------------
  // Driver: present words at the falling edge. Hold the word until it is
  // taken, then either idle for a burst or advance to the next one.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold the stalled word as is
    end else if (gap_left > 0 && !quiet) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (byte_queue.size() == 0) begin
      in_valid <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      gap_left = $urandom_range(0, 8);
    end else begin
      {option_byte, last_byte} <= byte_queue.pop_front();
      in_valid <= 1'b1;
    end
  end

  // Receiver: random stall bursts, the long hold-off, nothing in the tail.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (long_hold) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0 && !quiet) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Long hold-off: once the run of back-to-back tiny packets starts, stop
  // taking results so the output and skid registers fill and in_stall rises.
  initial begin
    long_hold = 1'b0;
    wait (!rst && words_in >= pressure_mark);
    @(posedge clk);
    long_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int random_bytes;
    int start_size;

    quiet_mark    = 32'h7FFF_FFFF;
    pressure_mark = 32'h7FFF_FFFF;

    // Max message type and all-ones mask, END, then a junk byte to drop.
    pkt = '{CODE_MSG_TYPE, 8'd1, 8'hFF,
            CODE_NETMASK, 8'd4, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            CODE_END, 8'hAB};
    send_packet();
    // Pad, short MTU, zero-length router, lease with an extra byte, then a
    // name server cut off mid-value.
    pkt = '{CODE_PAD,
            CODE_MTU, 8'd1, 8'h12,
            CODE_ROUTER, 8'd0,
            CODE_LEASE, 8'd5, 8'h80, 8'h00, 8'h00, 8'h01, 8'h77,
            CODE_NAME_SERVER, 8'd4, 8'hC0, 8'hA8};
    send_packet();
    // Lone END that is also the last byte.
    pkt = '{CODE_END};
    send_packet();
    // Last byte completes the rebinding time.
    pkt = '{CODE_REBINDING, 8'd4, 8'h00, 8'h01, 8'h51, 8'h80};
    send_packet();

    // Enough name server options to saturate the count.
    repeat (NS_REPEATS) add_option(CODE_NAME_SERVER, 4);
    pkt.push_back(CODE_END);
    send_packet();

    // Back-to-back tiny packets for the hold-off.
    pressure_mark = byte_queue.size();
    repeat (12) begin
      pkt = '{CODE_END};
      send_packet();
      pkt = '{CODE_MSG_TYPE, 8'd1, 8'($urandom_range(0, 255)), CODE_END};
      send_packet();
    end

    start_size = byte_queue.size();
    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      build_random_packet();
      random_bytes = byte_queue.size() - start_size;
    end
    total_words = byte_queue.size();
    quiet_mark  = total_words - QUIET_TAIL;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (words_in == total_words && pending_records.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_records.size() != 0) begin
      $error("%0d expected records never arrived", pending_records.size());
      errors++;
    end

    $display("Sent %0d option bytes in %0d packets, checked %0d records.",
             words_in, packets_in, records_checked);
    $display("Input was held back for %0d cycles while results backed up.",
             input_stall_cycles);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(LIMIT_NS);
    $display("Run did not finish in time.");
    $display("== FAIL ==");
    $finish;
  end

endmodule
